/* src/pcg_pkg.sv */
package pcg_pkg;

	localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;

	localparam logic [1:0] MODE_RAW      = 2'd0;
	localparam logic [1:0] MODE_BOUNDED  = 2'd1;
	localparam logic [1:0] MODE_FRACTION = 2'd2;

	localparam logic [1:0] CFG_SEED_STATE    = 2'd0;
	localparam logic [1:0] CFG_SEED_SEQUENCE = 2'd1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] limit;
		logic [6:0]  count;
	} pcg_req_t;

	typedef struct packed {
		logic [52:0] value;
		logic        bad_limit;
		logic        last;
	} pcg_rsp_t;

	typedef struct packed {
		logic        done;
		logic [63:0] next_state;
		logic [31:0] draw;
	} pcg_draw_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEED_A,
		S_SEED_AW,
		S_SEED_B,
		S_SEED_BW,
		S_PREP,
		S_THR,
		S_THR_W,
		S_NEXT,
		S_DRAW,
		S_DRAW_W,
		S_MOD,
		S_MOD_W,
		S_EMIT
	} pcg_state_t;

endpackage

/* src/pcg_draw.sv */
module pcg_draw (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [63:0]           old_state,
	input  logic [63:0]           increment,
	output pcg_pkg::pcg_draw_res_t res
);
	import pcg_pkg::*;

	logic [63:0] a_q;
	logic [63:0] inc_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] draw_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] xs;
	logic [63:0] rot_wide;

	// Output permutation: xorshift high bits, then rotate right by the top five bits.
	assign xs       = 32'(((old_state >> 18) ^ old_state) >> 27);
	assign rot_wide = {xs, xs} >> old_state[63:59];

	always_comb begin
		case (step_q)
			2'd0: begin
				mul_a = a_q[31:0];
				mul_b = LCG_MULT[31:0];
			end
			2'd1: begin
				mul_a = a_q[31:0];
				mul_b = LCG_MULT[63:32];
			end
			default: begin
				mul_a = a_q[63:32];
				mul_b = LCG_MULT[31:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= old_state;
			inc_q  <= increment;
			draw_q <= rot_wide[31:0];
		end
		if (busy_q) begin
			prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
			case (step_q)
				2'd0: ;
				2'd1: acc_q <= prod_q + inc_q;
				default: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
			endcase
		end
	end

	assign res.done       = done_q;
	assign res.next_state = acc_q;
	assign res.draw       = draw_q;

endmodule

/* src/pcg_rem.sv */
module pcg_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] remainder
);
	import pcg_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] div_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 32'd0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (!diff[32]) begin
				rem_q <= diff[31:0];
			end else begin
				rem_q <= trial[31:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

/* src/pcg32_random_generator_unit.sv */
// Channel   Direction  Handshake               Carries
// req       in         req_valid / req_stall   mode, limit, count
// rsp       out        rsp_valid / rsp_stall   value, bad_limit, last
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request is taken at a time; req_stall is high until its last result is loaded.
// Each draw runs through the shared 32x32 multiplier; a fraction result takes two draws.
// Bounded mode computes the rejection threshold once per request and one remainder
// per result in the one-bit-per-cycle remainder unit, and redraws after each rejected draw.
// Seeding adds two draws to the first request after reset or a write to either seed register.
// A stalled result holds in the output register and pauses the burst; cfg_ready is always high.
module pcg32_random_generator_unit #(
	parameter int MAX_BURST = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  pcg_pkg::pcg_req_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output pcg_pkg::pcg_rsp_t rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [63:0]      cfg_data
);
	import pcg_pkg::*;

	localparam int CntW = $clog2(MAX_BURST + 1);

	pcg_state_t    state_q;
	pcg_state_t    state_d;
	pcg_draw_res_t draw_res;

	logic [63:0]     seed_state_q;
	logic [62:0]     seed_seq_q;
	logic [63:0]     lcg_state_q;
	logic [63:0]     lcg_inc_q;
	logic            seeded_q;
	logic [1:0]      mode_q;
	logic [31:0]     limit_q;
	logic [CntW-1:0] left_q;
	logic            half_q;
	logic [31:0]     thr_q;
	logic [52:0]     val_q;
	logic            rsp_valid_q;
	pcg_rsp_t        rsp_q;

	logic        req_fire;
	logic        cfg_fire;
	logic        slot_free;
	logic        draw_start;
	logic        rem_start;
	logic        rem_done;
	logic [31:0] rem_val;
	logic [31:0] rem_dividend;
	logic        rsp_load;
	logic        is_bounded;
	logic        is_bad;
	logic        is_fraction;
	logic [CntW-1:0] burst_len;

	assign req_stall   = (state_q != S_IDLE);
	assign req_fire    = req_valid && !req_stall;
	assign cfg_ready   = 1'b1;
	assign cfg_fire    = cfg_valid && cfg_ready;
	assign slot_free   = !rsp_valid_q || !rsp_stall;
	assign is_bounded  = (mode_q == MODE_BOUNDED);
	assign is_fraction = (mode_q == MODE_FRACTION);
	assign is_bad      = is_bounded && (limit_q == 32'd0);
	assign burst_len   = (32'(req.count) > MAX_BURST) ? CntW'(MAX_BURST) : CntW'(req.count);
	assign rem_dividend = (state_q == S_THR) ? (32'd0 - limit_q) : val_q[31:0];

	pcg_draw u_draw (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (draw_start),
		.old_state (lcg_state_q),
		.increment (lcg_inc_q),
		.res       (draw_res)
	);

	pcg_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (rem_dividend),
		.divisor   (limit_q),
		.done      (rem_done),
		.remainder (rem_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		draw_start = 1'b0;
		rem_start  = 1'b0;
		rsp_load   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire && (req.count != 7'd0)) begin
					state_d = seeded_q ? S_PREP : S_SEED_A;
				end
			end
			S_SEED_A: begin
				draw_start = 1'b1;
				state_d    = S_SEED_AW;
			end
			S_SEED_AW: begin
				if (draw_res.done) begin
					state_d = S_SEED_B;
				end
			end
			S_SEED_B: begin
				draw_start = 1'b1;
				state_d    = S_SEED_BW;
			end
			S_SEED_BW: begin
				if (draw_res.done) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				state_d = (is_bounded && !is_bad) ? S_THR : S_NEXT;
			end
			S_THR: begin
				rem_start = 1'b1;
				state_d   = S_THR_W;
			end
			S_THR_W: begin
				if (rem_done) begin
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				state_d = is_bad ? S_EMIT : S_DRAW;
			end
			S_DRAW: begin
				draw_start = 1'b1;
				state_d    = S_DRAW_W;
			end
			S_DRAW_W: begin
				if (draw_res.done) begin
					if (is_bounded) begin
						state_d = (draw_res.draw < thr_q) ? S_DRAW : S_MOD;
					end else if (is_fraction && !half_q) begin
						state_d = S_DRAW;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_MOD: begin
				rem_start = 1'b1;
				state_d   = S_MOD_W;
			end
			S_MOD_W: begin
				if (rem_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (slot_free) begin
					rsp_load = 1'b1;
					state_d  = (left_q == CntW'(1)) ? S_IDLE : S_NEXT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_state_q <= 64'd0;
			seed_seq_q   <= 63'd0;
			lcg_state_q  <= 64'd0;
			lcg_inc_q    <= 64'd1;
			seeded_q     <= 1'b0;
			left_q       <= '0;
			half_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg_index)
					CFG_SEED_STATE: begin
						seed_state_q <= cfg_data;
						seeded_q     <= 1'b0;
					end
					CFG_SEED_SEQUENCE: begin
						seed_seq_q <= cfg_data[62:0];
						seeded_q   <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == S_IDLE && req_fire) begin
				left_q <= burst_len;
				half_q <= 1'b0;
				if (!seeded_q) begin
					lcg_state_q <= 64'd0;
					lcg_inc_q   <= {seed_seq_q, 1'b1};
				end
			end
			if (state_q == S_SEED_AW && draw_res.done) begin
				lcg_state_q <= draw_res.next_state + seed_state_q;
			end
			if (state_q == S_SEED_BW && draw_res.done) begin
				lcg_state_q <= draw_res.next_state;
				seeded_q    <= 1'b1;
			end
			if (state_q == S_DRAW_W && draw_res.done) begin
				lcg_state_q <= draw_res.next_state;
				if (is_fraction) begin
					half_q <= !half_q;
				end
			end
			if (rsp_load) begin
				left_q      <= left_q - CntW'(1);
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_q  <= req.mode;
			limit_q <= req.limit;
		end
		if (state_q == S_THR_W && rem_done) begin
			thr_q <= rem_val;
		end
		if (state_q == S_NEXT && is_bad) begin
			val_q <= 53'd0;
		end
		if (state_q == S_DRAW_W && draw_res.done) begin
			if (is_fraction && !half_q) begin
				val_q <= {draw_res.draw[31:5], 26'd0};
			end else if (is_fraction) begin
				val_q <= {val_q[52:26], draw_res.draw[31:6]};
			end else begin
				val_q <= {21'd0, draw_res.draw};
			end
		end
		if (state_q == S_MOD_W && rem_done) begin
			val_q <= {21'd0, rem_val};
		end
		if (rsp_load) begin
			rsp_q.value     <= val_q;
			rsp_q.bad_limit <= is_bad;
			rsp_q.last      <= (left_q == CntW'(1));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.bad_limit |-> rsp_q.value == 53'd0)
		else $error("flagged result carries a nonzero value");

	a_bounded_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && is_bounded && !is_bad |=>
			rsp_q.value[52:32] == 21'd0 && rsp_q.value[31:0] < limit_q)
		else $error("bounded result not below the limit");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load && left_q == CntW'(1) |=> state_q == S_IDLE && rsp_q.last)
		else $error("burst did not end on its last result");

	a_seeded_draws: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NEXT |-> seeded_q)
		else $error("result drawn before seeding");

endmodule

/* dv/pcg32_checker.sv */
module pcg32_checker #(
	parameter int MAX_BURST = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  pcg_pkg::pcg_req_t req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  pcg_pkg::pcg_rsp_t rsp,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	output int                fail_count,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pcg_pkg::*;

	logic [63:0] seed_add;
	logic [62:0] stream_sel;
	logic [63:0] gen_state;
	logic [63:0] gen_incr;
	logic        is_seeded;
	pcg_rsp_t    result_q[$];
	pcg_rsp_t    want;

	function automatic logic [31:0] next_word();
		logic [63:0] prev;
		logic [63:0] folded;
		logic [31:0] mixed;
		logic [4:0]  turn;
		logic [63:0] twice;
		prev = gen_state;
		gen_state = prev * LCG_MULT + gen_incr;
		folded = ((prev >> 18) ^ prev) >> 27;
		mixed = folded[31:0];
		turn = prev[63:59];
		twice = {mixed, mixed} >> turn;
		return twice[31:0];
	endfunction

	function automatic void reseed();
		logic [31:0] discard;
		gen_state = '0;
		gen_incr = {stream_sel, 1'b1};
		discard = next_word();
		gen_state = gen_state + seed_add;
		discard = next_word();
		is_seeded = 1'b1;
	endfunction

	function automatic void predict_burst(pcg_req_t r);
		int          n;
		logic [31:0] floor_ok;
		logic [31:0] w;
		logic [31:0] hi_w;
		pcg_rsp_t    e;
		n = int'(r.count);
		if (n == 0)
			return;
		if (n > MAX_BURST)
			n = MAX_BURST;
		if (!is_seeded)
			reseed();
		for (int k = 0; k < n; k++) begin
			e = '0;
			e.last = (k == n - 1);
			if (r.mode == MODE_BOUNDED) begin
				if (r.limit == 32'd0) begin
					e.bad_limit = 1'b1;
				end else begin
					floor_ok = (32'd0 - r.limit) % r.limit;
					do
						w = next_word();
					while (w < floor_ok);
					w = w % r.limit;
					e.value = {21'd0, w};
				end
			end else if (r.mode == MODE_FRACTION) begin
				hi_w = next_word();
				w = next_word();
				e.value = {hi_w[31:5], w[31:6]};
			end else begin
				w = next_word();
				e.value = {21'd0, w};
			end
			result_q.push_back(e);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_add = '0;
			stream_sel = '0;
			gen_state = '0;
			gen_incr = 64'd1;
			is_seeded = 1'b0;
			result_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SEED_STATE) begin
					seed_add = cfg_data;
					is_seeded = 1'b0;
				end else if (cfg_index == CFG_SEED_SEQUENCE) begin
					stream_sel = cfg_data[62:0];
					is_seeded = 1'b0;
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (result_q.size() == 0) begin
					$error("unexpected result: value %h bad_limit %b last %b",
						rsp.value, rsp.bad_limit, rsp.last);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					if (rsp.value !== want.value) begin
						$error("value: expected %h, got %h", want.value, rsp.value);
						fail_count++;
					end
					if (rsp.bad_limit !== want.bad_limit) begin
						$error("bad_limit: expected %b, got %b", want.bad_limit, rsp.bad_limit);
						fail_count++;
					end
					if (rsp.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, rsp.last);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				predict_burst(req);
			pending = result_q.size();
		end
	end

endmodule

/* dv/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pcg_pkg::*;

	localparam int         MAX_BURST     = 64;
	localparam int         SETTLE_CYCLES = 200;
	localparam logic [1:0] MODE_SPARE    = 2'd3;
	localparam logic [1:0] CFG_SPARE_LO  = 2'd2;
	localparam logic [1:0] CFG_SPARE_HI  = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	pcg_req_t    req;
	logic        rsp_valid;
	logic        rsp_stall;
	pcg_rsp_t    rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          pending;
	int          burst_left;
	pcg_req_t    plan[$];

	pcg32_random_generator_unit #(
		.MAX_BURST(MAX_BURST)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pcg32_checker #(
		.MAX_BURST(MAX_BURST)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic pcg_req_t req_of(logic [1:0] mode, logic [31:0] limit, logic [6:0] count);
		pcg_req_t r;
		r.mode = mode;
		r.limit = limit;
		r.count = count;
		return r;
	endfunction

	function automatic pcg_req_t random_req();
		pcg_req_t r;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			r.mode = MODE_RAW;
		else if (pick < 65)
			r.mode = MODE_BOUNDED;
		else if (pick < 90)
			r.mode = MODE_FRACTION;
		else
			r.mode = MODE_SPARE;
		r.limit = $urandom;
		if (r.mode == MODE_BOUNDED) begin
			case ($urandom_range(0, 9))
			0: begin
				r.limit = 32'd0;
			end
			1, 2: begin
				r.limit = $urandom_range(1, 16);
			end
			3: begin
				r.limit = 32'd1 << $urandom_range(0, 31);
			end
			4: begin
				r.limit = 32'h8000_0000 + $urandom_range(1, 1000);
			end
			5: begin
				r.limit = 32'hFFFF_FFFF - $urandom_range(0, 15);
			end
			default: begin
				r.limit = $urandom;
			end
			endcase
		end
		pick = $urandom_range(0, 99);
		if (pick < 80)
			r.count = 7'($urandom_range(1, 8));
		else if (pick < 92)
			r.count = 7'($urandom_range(9, 63));
		else if (pick < 95)
			r.count = 7'd64;
		else if (pick < 98)
			r.count = 7'($urandom_range(65, 127));
		else
			r.count = 7'd0;
		return r;
	endfunction

	task automatic send_req(input pcg_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		burst_left = 0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int style;
		int span;
		rsp_stall = 1'b0;
		span = 0;
		style = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				style = $urandom_range(0, 3);
				span = $urandom_range(20, 200);
			end
			span--;
			case (style)
			0: begin
				rsp_stall <= 1'b0;
			end
			1: begin
				rsp_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				rsp_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				rsp_stall <= span[3];
			end
			endcase
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		plan.push_back(req_of(MODE_RAW, 32'd0, 7'd0));
		plan.push_back(req_of(MODE_RAW, 32'd0, 7'd1));
		plan.push_back(req_of(MODE_RAW, 32'hFFFF_FFFF, 7'd64));
		plan.push_back(req_of(MODE_RAW, 32'h5A5A_A5A5, 7'd127));
		plan.push_back(req_of(MODE_RAW, 32'd7, 7'd65));
		plan.push_back(req_of(MODE_SPARE, 32'd9, 7'd3));
		plan.push_back(req_of(MODE_BOUNDED, 32'd0, 7'd4));
		plan.push_back(req_of(MODE_BOUNDED, 32'd1, 7'd3));
		plan.push_back(req_of(MODE_BOUNDED, 32'd3, 7'd5));
		plan.push_back(req_of(MODE_BOUNDED, 32'hFFFF_FFFF, 7'd3));
		plan.push_back(req_of(MODE_BOUNDED, 32'h8000_0000, 7'd2));
		plan.push_back(req_of(MODE_BOUNDED, 32'h8000_0001, 7'd4));
		plan.push_back(req_of(MODE_BOUNDED, 32'd0, 7'd0));
		plan.push_back(req_of(MODE_FRACTION, 32'd0, 7'd1));
		plan.push_back(req_of(MODE_FRACTION, 32'd0, 7'd64));
		plan.push_back(req_of(MODE_FRACTION, 32'hFFFF_FFFF, 7'd2));
		foreach (plan[i])
			send_req(plan[i]);

		for (int p = 0; p < 4; p++) begin
			settle();
			case (p)
			0: begin
				write_reg(CFG_SEED_STATE, '1);
				write_reg(CFG_SEED_SEQUENCE, '1);
			end
			1: begin
				write_reg(CFG_SEED_STATE, '0);
				write_reg(CFG_SEED_SEQUENCE, '0);
			end
			2: begin
				write_reg(CFG_SEED_STATE, {$urandom, $urandom});
				write_reg(CFG_SEED_SEQUENCE, {$urandom, $urandom});
				write_reg(CFG_SPARE_LO, {$urandom, $urandom});
				write_reg(CFG_SPARE_HI, {$urandom, $urandom});
			end
			default: begin
				write_reg(CFG_SEED_SEQUENCE, 64'h7FFF_FFFF_FFFF_FFFF);
			end
			endcase
			cfg_valid <= 1'b0;
			repeat (38) send_req(random_req());
		end
		settle();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#200ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
